// File: rtl/core/stri_pkg.sv
// Shared constants for the segment/triangle interior hit core.
// No dependencies; imported by the top level and the testbench.
package stri_pkg;

    localparam int FIELD_W    = 63;  // packed x,y,z input word
    localparam int EPS_W      = 20;  // world epsilon, Q16.4
    localparam int MARGIN_W   = 16;  // barycentric margin, Q0.16
    localparam int CFG_W      = 20;  // config data, widest register
    localparam int CFG_IDX_W  = 1;
    localparam int Q_BITS     = 30;  // fraction bits of the crossing parameter
    localparam int EPS_SHIFT  = 19;  // Q16.4 epsilon to Q.23 distance
    localparam int ONE_SHIFT  = 16;  // 1.0 in Q0.16
    localparam int PAR_LIMIT  = 9;   // near-parallel bound on raw Q.23 distance

    localparam logic [19:0] EPS_RESET    = 20'd1;
    localparam logic [15:0] MARGIN_RESET = 16'd66;

    localparam logic [CFG_IDX_W-1:0] REG_WORLD_EPS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BARY_MARGIN = 1'b1;

endpackage

// File: rtl/core/stri_wmul.sv
// Two-stage signed multiplier built from four half-width partial products.
// Depends on nothing; used by the top level for the wide barycentric terms.
module stri_wmul #(
    parameter int AW = 46,
    parameter int BW = 46
) (
    input  logic                     i_clk,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-1:0]  o_p
);
    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic        [AL-1:0]      w_a_lo;
    logic signed [AH-1:0]      w_a_hi;
    logic        [BL-1:0]      w_b_lo;
    logic signed [BH-1:0]      w_b_hi;
    logic        [AL+BL-1:0]   r_ll;
    logic signed [AH+BL:0]     r_hl;
    logic signed [AL+BH:0]     r_lh;
    logic signed [AH+BH-1:0]   r_hh;
    logic signed [PW-1:0]      w_ll;
    logic signed [PW-1:0]      w_hl;
    logic signed [PW-1:0]      w_lh;
    logic signed [PW-1:0]      w_hh;

    assign w_a_lo = i_a[AL-1:0];
    assign w_a_hi = $signed(i_a[AW-1:AL]);
    assign w_b_lo = i_b[BL-1:0];
    assign w_b_hi = $signed(i_b[BW-1:BL]);

    always_ff @(posedge i_clk) begin
        r_ll <= w_a_lo * w_b_lo;
        r_hl <= w_a_hi * $signed({1'b0, w_b_lo});
        r_lh <= $signed({1'b0, w_a_lo}) * w_b_hi;
        r_hh <= w_a_hi * w_b_hi;
    end

    // align partials, then one sum
    assign w_ll = $signed(PW'(r_ll));
    assign w_hl = PW'(r_hl) <<< AL;
    assign w_lh = PW'(r_lh) <<< BL;
    assign w_hh = PW'(r_hh) <<< (AL + BL);

    always_ff @(posedge i_clk) begin
        o_p <= w_hh + w_hl + w_lh + w_ll;
    end

endmodule

// File: rtl/core/stri_tdiv.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on nothing; carries an opaque sideband alongside each beat.
module stri_tdiv #(
    parameter int NW = 46,
    parameter int QW = 30,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    logic [NW-1:0] r_rem  [QW];
    logic [NW-1:0] r_den  [QW];
    logic [QW-1:0] r_q    [QW];
    logic [SW-1:0] r_side [QW];
    logic [QW-1:0] r_v;

    logic [NW-1:0] n_rem  [QW];
    logic [QW-1:0] n_q    [QW];
    logic [NW-1:0] s_rem  [QW];
    logic [NW-1:0] s_den  [QW];
    logic [QW-1:0] s_q    [QW];
    logic [SW-1:0] s_side [QW];

    always_comb begin
        logic [NW:0] sh;
        logic [NW:0] df;
        sh = '0;
        df = '0;
        s_rem[0]  = i_num;
        s_den[0]  = i_den;
        s_q[0]    = '0;
        s_side[0] = i_side;
        for (int k = 1; k < QW; k++) begin
            s_rem[k]  = r_rem[k-1];
            s_den[k]  = r_den[k-1];
            s_q[k]    = r_q[k-1];
            s_side[k] = r_side[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            sh = {s_rem[k], 1'b0};
            df = sh - {1'b0, s_den[k]};
            if (sh >= {1'b0, s_den[k]}) begin
                n_rem[k] = df[NW-1:0];
                n_q[k]   = {s_q[k][QW-2:0], 1'b1};
            end else begin
                n_rem[k] = sh[NW-1:0];
                n_q[k]   = {s_q[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            r_rem[k]  <= n_rem[k];
            r_den[k]  <= s_den[k];
            r_q[k]    <= n_q[k];
            r_side[k] <= s_side[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[QW-2:0], i_valid};
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_q[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// File: rtl/core/segment_triangle_interior_hit_core.sv
// Segment/triangle strict-interior crossing test, top level.
// Depends on stri_pkg, stri_tdiv (crossing parameter) and stri_wmul (wide products).
//
// Usage:
//   Command channel: raise i_start with the six packed words (segment ends,
//   three corners, unit normal). o_busy never rises, so a beat is taken on
//   every cycle that i_start is high.
//   Result channel: o_valid pulses for one cycle with o_hit and the crossing
//   point; the point reads zero on a miss. Results leave in accept order.
//   Pipeline: Q_BITS + 17 register stages lie between the accept edge and the
//   strobe; the 30-stage divider for the crossing parameter is the bulk of them.
//   Throughput: one beat per cycle, fully pipelined.
//   Config: write i_cfg_data to register i_cfg_idx (world epsilon, then
//   barycentric margin) with i_cfg_we; write only while no beat is in flight.
//   Reset: synchronous, active low; clears the valid chain and loads the
//   register defaults. The receiver cannot stall, so nothing ever holds.
module segment_triangle_interior_hit_core #(
    parameter int COORD_WIDTH = 21
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [stri_pkg::FIELD_W-1:0]     i_seg_start,
    input  logic [stri_pkg::FIELD_W-1:0]     i_seg_end,
    input  logic [stri_pkg::FIELD_W-1:0]     i_corner_a,
    input  logic [stri_pkg::FIELD_W-1:0]     i_corner_b,
    input  logic [stri_pkg::FIELD_W-1:0]     i_corner_c,
    input  logic [stri_pkg::FIELD_W-1:0]     i_plane_normal,
    input  logic                             i_cfg_we,
    input  logic [stri_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [stri_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                             o_valid,
    output logic                             o_hit,
    output logic signed [20:0]               o_point_x,
    output logic signed [20:0]               o_point_y,
    output logic signed [20:0]               o_point_z
);
    import stri_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int D0W  = 2 * W + 3;          // plane distance
    localparam int NW   = 2 * W + 4;          // divider operands
    localparam int EPW  = EPS_W + EPS_SHIFT;
    localparam int CMW  = ((D0W > EPW + 1) ? D0W : EPW + 1) + 1;
    localparam int MGW  = W + Q_BITS + 1;     // |dd| * t
    localparam int DOTW = 2 * W + 4;
    localparam int PRW  = 2 * DOTW;           // wide product
    localparam int XW   = PRW + 1;
    localparam int UW   = XW + 2;
    localparam int MBW  = MARGIN_W + 1;
    localparam int RHW  = XW + MBW;
    localparam int CW   = UW + ONE_SHIFT + 1;
    localparam int NPRE = 6;                  // stages before the divider
    localparam int NPST = 11;                 // stages after the divider
    localparam int NTL  = 9;                  // tail carry stages

    typedef struct packed {
        logic [2:0][W-1:0] s;
        logic [2:0][W-1:0] a;
        logic [2:0][W-1:0] ddm;
        logic [2:0]        ddn;
        logic [2:0][W:0]   v0;
        logic [2:0][W:0]   v1;
        logic              miss;
        logic              eq;
    } t_side;

    typedef struct packed {
        logic [2:0][W-1:0] p;
        logic              miss;
    } t_tail;

    // ---------------- configuration ----------------
    logic [EPS_W-1:0]    r_world_eps;
    logic [MARGIN_W-1:0] r_bary_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_world_eps   <= EPS_RESET;
            r_bary_margin <= MARGIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WORLD_EPS:   r_world_eps   <= i_cfg_data[EPS_W-1:0];
                REG_BARY_MARGIN: r_bary_margin <= i_cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // ---------------- valid chains ----------------
    logic            w_accept;
    logic [NPRE-1:0] r_va;
    logic [NPST-1:0] r_vb;
    logic            w_div_v;

    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= '0;
            r_vb <= '0;
        end else begin
            r_va <= {r_va[NPRE-2:0], w_accept};
            r_vb <= {r_vb[NPST-2:0], w_div_v};
        end
    end

    // ---------------- stage 0: capture beat ----------------
    logic [FIELD_W-1:0] r0_s, r0_e, r0_a, r0_b, r0_c, r0_n;

    always_ff @(posedge i_clk) begin
        r0_s <= i_seg_start;
        r0_e <= i_seg_end;
        r0_a <= i_corner_a;
        r0_b <= i_corner_b;
        r0_c <= i_corner_c;
        r0_n <= i_plane_normal;
    end

    // ---------------- stage 1: edge vectors ----------------
    t_side             n1_sd, r1_sd;
    logic [2:0][W:0]   n1_ds, n1_de, r1_ds, r1_de;
    logic [2:0][W-1:0] r1_n;

    always_comb begin
        logic signed [W-1:0] cs, ce, ca, cb, cc;
        logic signed [W:0]   dd;
        n1_sd = '0;
        n1_ds = '0;
        n1_de = '0;
        for (int k = 0; k < 3; k++) begin
            cs = $signed(r0_s[k*W +: W]);
            ce = $signed(r0_e[k*W +: W]);
            ca = $signed(r0_a[k*W +: W]);
            cb = $signed(r0_b[k*W +: W]);
            cc = $signed(r0_c[k*W +: W]);
            dd = (W+1)'(ce) - (W+1)'(cs);
            n1_ds[k]     = (W+1)'(cs) - (W+1)'(ca);
            n1_de[k]     = (W+1)'(ce) - (W+1)'(ca);
            n1_sd.v0[k]  = (W+1)'(cb) - (W+1)'(ca);
            n1_sd.v1[k]  = (W+1)'(cc) - (W+1)'(ca);
            n1_sd.s[k]   = cs;
            n1_sd.a[k]   = ca;
            n1_sd.ddn[k] = dd[W];
            n1_sd.ddm[k] = dd[W] ? W'(-dd) : W'(dd);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sd <= n1_sd;
        r1_ds <= n1_ds;
        r1_de <= n1_de;
        for (int k = 0; k < 3; k++) begin
            r1_n[k] <= r0_n[k*W +: W];
        end
    end

    // ---------------- stage 2: distance products ----------------
    t_side                    r2_sd;
    logic signed [2*W:0]      r2_p0 [3];
    logic signed [2*W:0]      r2_p1 [3];

    always_ff @(posedge i_clk) begin
        r2_sd <= r1_sd;
        for (int k = 0; k < 3; k++) begin
            r2_p0[k] <= $signed(r1_ds[k]) * $signed(r1_n[k]);
            r2_p1[k] <= $signed(r1_de[k]) * $signed(r1_n[k]);
        end
    end

    // ---------------- stage 3: plane distances ----------------
    t_side                 r3_sd;
    logic signed [D0W-1:0] r3_d0, r3_d1;

    always_ff @(posedge i_clk) begin
        r3_sd <= r2_sd;
        r3_d0 <= D0W'(r2_p0[0]) + D0W'(r2_p0[1]) + D0W'(r2_p0[2]);
        r3_d1 <= D0W'(r2_p1[0]) + D0W'(r2_p1[1]) + D0W'(r2_p1[2]);
    end

    // ---------------- stage 4: same side, near parallel ----------------
    t_side                 n4_sd, r4_sd;
    logic signed [D0W-1:0] r4_d0;
    logic signed [NW-1:0]  n4_den, r4_den;
    logic signed [CMW-1:0] w_eps, w_d0c, w_d1c;

    assign w_eps = $signed(CMW'({r_world_eps, {EPS_SHIFT{1'b0}}}));
    assign w_d0c = CMW'(r3_d0);
    assign w_d1c = CMW'(r3_d1);

    always_comb begin
        n4_sd  = r3_sd;
        n4_den = NW'(r3_d0) - NW'(r3_d1);
        n4_sd.miss = (w_d0c > w_eps && w_d1c > w_eps)
                  || (w_d0c < -w_eps && w_d1c < -w_eps)
                  || (n4_den > -PAR_LIMIT && n4_den < PAR_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        r4_sd  <= n4_sd;
        r4_d0  <= r3_d0;
        r4_den <= n4_den;
    end

    // ---------------- stage 5: fold sign into numerator ----------------
    t_side                r5_sd;
    logic signed [NW-1:0] r5_num;
    logic [NW-1:0]        r5_den;

    always_ff @(posedge i_clk) begin
        r5_sd <= r4_sd;
        if (r4_den[NW-1]) begin
            r5_num <= -NW'(r4_d0);
            r5_den <= NW'(-r4_den);
        end else begin
            r5_num <= NW'(r4_d0);
            r5_den <= NW'(r4_den);
        end
    end

    // ---------------- divider: t = num / den ----------------
    t_side                w_div_in_sd, w_div_out_sd;
    logic [$bits(t_side)-1:0] w_div_side;
    logic [Q_BITS-1:0]    w_quo;

    always_comb begin
        w_div_in_sd      = r5_sd;
        // crossing off the segment
        w_div_in_sd.miss = r5_sd.miss || r5_num[NW-1]
                        || ($unsigned(r5_num) > r5_den);
        w_div_in_sd.eq   = ($unsigned(r5_num) == r5_den);
    end

    stri_tdiv #(
        .NW (NW),
        .QW (Q_BITS),
        .SW ($bits(t_side))
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_va[NPRE-1]),
        .i_num   ($unsigned(r5_num)),
        .i_den   (r5_den),
        .i_side  (w_div_in_sd),
        .o_valid (w_div_v),
        .o_quo   (w_quo),
        .o_side  (w_div_side)
    );

    assign w_div_out_sd = t_side'(w_div_side);

    // ---------------- stage 6: |dd| * t ----------------
    t_side             r6_sd;
    logic [MGW-1:0]    r6_mag [3];
    logic [Q_BITS:0]   w_tq;

    assign w_tq = w_div_out_sd.eq ? {1'b1, {Q_BITS{1'b0}}} : {1'b0, w_quo};

    always_ff @(posedge i_clk) begin
        r6_sd <= w_div_out_sd;
        for (int k = 0; k < 3; k++) begin
            r6_mag[k] <= w_div_out_sd.ddm[k] * w_tq;
        end
    end

    // ---------------- stage 7: crossing point, round half away ----------------
    t_tail             n7_tl;
    t_tail             r_tl [NTL];
    logic [2:0][W:0]   r7_v0, r7_v1;
    logic [2:0][W-1:0] r7_a;

    always_comb begin
        logic [MGW:0]      rnd;
        logic [W:0]        r;
        logic signed [W+1:0] pt;
        rnd = '0;
        r   = '0;
        pt  = '0;
        n7_tl.miss = r6_sd.miss;
        n7_tl.p    = '0;
        for (int k = 0; k < 3; k++) begin
            rnd = (MGW+1)'(r6_mag[k]) + (MGW+1)'({1'b1, {(Q_BITS-1){1'b0}}});
            r   = rnd[Q_BITS +: W+1];
            if (r6_sd.ddn[k]) begin
                pt = (W+2)'($signed(r6_sd.s[k])) - $signed({1'b0, r});
            end else begin
                pt = (W+2)'($signed(r6_sd.s[k])) + $signed({1'b0, r});
            end
            n7_tl.p[k] = pt[W-1:0];
        end
    end

    // tail shift line: point and miss ride to the output
    always_ff @(posedge i_clk) begin
        r_tl[0] <= n7_tl;
        for (int k = 1; k < NTL; k++) begin
            r_tl[k] <= r_tl[k-1];
        end
        r7_v0 <= r6_sd.v0;
        r7_v1 <= r6_sd.v1;
        r7_a  <= r6_sd.a;
    end

    // ---------------- stage 8: v2 = p - a ----------------
    logic [2:0][W:0] r8_v0, r8_v1, r8_v2;

    always_ff @(posedge i_clk) begin
        r8_v0 <= r7_v0;
        r8_v1 <= r7_v1;
        for (int k = 0; k < 3; k++) begin
            r8_v2[k] <= (W+1)'($signed(r_tl[0].p[k])) - (W+1)'($signed(r7_a[k]));
        end
    end

    // ---------------- stage 9: dot products, per component ----------------
    logic signed [2*W+1:0] r9_00 [3], r9_01 [3], r9_11 [3], r9_20 [3], r9_21 [3];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r9_00[k] <= $signed(r8_v0[k]) * $signed(r8_v0[k]);
            r9_01[k] <= $signed(r8_v0[k]) * $signed(r8_v1[k]);
            r9_11[k] <= $signed(r8_v1[k]) * $signed(r8_v1[k]);
            r9_20[k] <= $signed(r8_v2[k]) * $signed(r8_v0[k]);
            r9_21[k] <= $signed(r8_v2[k]) * $signed(r8_v1[k]);
        end
    end

    // ---------------- stage 10: dot sums ----------------
    logic signed [DOTW-1:0] r10_d00, r10_d01, r10_d11, r10_d20, r10_d21;

    always_ff @(posedge i_clk) begin
        r10_d00 <= DOTW'(r9_00[0]) + DOTW'(r9_00[1]) + DOTW'(r9_00[2]);
        r10_d01 <= DOTW'(r9_01[0]) + DOTW'(r9_01[1]) + DOTW'(r9_01[2]);
        r10_d11 <= DOTW'(r9_11[0]) + DOTW'(r9_11[1]) + DOTW'(r9_11[2]);
        r10_d20 <= DOTW'(r9_20[0]) + DOTW'(r9_20[1]) + DOTW'(r9_20[2]);
        r10_d21 <= DOTW'(r9_21[0]) + DOTW'(r9_21[1]) + DOTW'(r9_21[2]);
    end

    // ---------------- stages 11-12: wide products ----------------
    logic signed [PRW-1:0] w_m0011, w_m0101, w_m1120, w_m0121, w_m0021, w_m0120;

    stri_wmul #(.AW(DOTW), .BW(DOTW)) u_m0011 (
        .i_clk(i_clk), .i_a(r10_d00), .i_b(r10_d11), .o_p(w_m0011));
    stri_wmul #(.AW(DOTW), .BW(DOTW)) u_m0101 (
        .i_clk(i_clk), .i_a(r10_d01), .i_b(r10_d01), .o_p(w_m0101));
    stri_wmul #(.AW(DOTW), .BW(DOTW)) u_m1120 (
        .i_clk(i_clk), .i_a(r10_d11), .i_b(r10_d20), .o_p(w_m1120));
    stri_wmul #(.AW(DOTW), .BW(DOTW)) u_m0121 (
        .i_clk(i_clk), .i_a(r10_d01), .i_b(r10_d21), .o_p(w_m0121));
    stri_wmul #(.AW(DOTW), .BW(DOTW)) u_m0021 (
        .i_clk(i_clk), .i_a(r10_d00), .i_b(r10_d21), .o_p(w_m0021));
    stri_wmul #(.AW(DOTW), .BW(DOTW)) u_m0120 (
        .i_clk(i_clk), .i_a(r10_d01), .i_b(r10_d20), .o_p(w_m0120));

    // ---------------- stage 13: denom and weight numerators ----------------
    logic signed [XW-1:0] r13_den, r13_xv, r13_xw;

    always_ff @(posedge i_clk) begin
        r13_den <= XW'(w_m0011) - XW'(w_m0101);
        r13_xv  <= XW'(w_m1120) - XW'(w_m0121);
        r13_xw  <= XW'(w_m0021) - XW'(w_m0120);
    end

    // ---------------- stages 14-15: margin * denom ----------------
    logic signed [RHW-1:0] w_rhs;
    logic signed [UW-1:0]  r14_xu, r15_xu;
    logic signed [XW-1:0]  r14_xv, r14_xw, r15_xv, r15_xw;
    logic                  r14_dpos, r15_dpos;

    stri_wmul #(.AW(XW), .BW(MBW)) u_rhs (
        .i_clk(i_clk), .i_a(r13_den), .i_b($signed({1'b0, r_bary_margin})), .o_p(w_rhs));

    always_ff @(posedge i_clk) begin
        r14_xu   <= UW'(r13_den) - UW'(r13_xv) - UW'(r13_xw);
        r14_xv   <= r13_xv;
        r14_xw   <= r13_xw;
        r14_dpos <= !r13_den[XW-1] && (r13_den != '0);
        r15_xu   <= r14_xu;
        r15_xv   <= r14_xv;
        r15_xw   <= r14_xw;
        r15_dpos <= r14_dpos;
    end

    // ---------------- stage 16: interior test, result register ----------------
    logic signed [CW-1:0] w_lu, w_lv, w_lw, w_rc;
    logic                 w_hit;

    assign w_lu  = CW'(r15_xu) <<< ONE_SHIFT;
    assign w_lv  = CW'(r15_xv) <<< ONE_SHIFT;
    assign w_lw  = CW'(r15_xw) <<< ONE_SHIFT;
    assign w_rc  = CW'(w_rhs);
    assign w_hit = !r_tl[NTL-1].miss && r15_dpos
                && (w_lu > w_rc) && (w_lv > w_rc) && (w_lw > w_rc);

    always_ff @(posedge i_clk) begin
        o_hit     <= w_hit;
        // drop the point on a miss
        o_point_x <= w_hit ? 21'($signed(r_tl[NTL-1].p[0])) : '0;
        o_point_y <= w_hit ? 21'($signed(r_tl[NTL-1].p[1])) : '0;
        o_point_z <= w_hit ? 21'($signed(r_tl[NTL-1].p[2])) : '0;
    end

    assign o_valid = r_vb[NPST-1];

    // ---------------- checks ----------------
    a_div_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va[NPRE-1] |-> ##(Q_BITS) w_div_v)
        else $error("divider lost or delayed a beat");

    a_miss_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vb[NPST-2] && r_tl[NTL-1].miss) |=> (o_valid && !o_hit))
        else $error("early miss turned into a hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_point_x == '0 && o_point_y == '0 && o_point_z == '0))
        else $error("miss carries a nonzero point");

endmodule

// File: bench/segment_triangle_interior_hit_core_test.sv
`timescale 1ns / 1ps
// Testbench for segment_triangle_interior_hit_core: a command driver, a result
// monitor and a crossing predictor. Depends on stri_pkg and the core.
module segment_triangle_interior_hit_core_test;
    import stri_pkg::*;

    localparam int CW       = 21;
    localparam int LATENCY  = Q_BITS + 17;
    localparam int WATCHDOG = 4000;
    localparam longint NORM_ONE = 524287;  // just under 1.0 in Q1.19

    typedef logic signed [127:0] wide_t;

    // One command beat: segment ends, three corners, unit normal.
    typedef struct {
        logic [FIELD_W-1:0] s, e, a, b, c, n;
    } seg_tri_t;

    // One result beat.
    typedef struct {
        logic              hit;
        logic signed [20:0] x, y, z;
    } crossing_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [FIELD_W-1:0] i_seg_start = '0, i_seg_end = '0;
    logic [FIELD_W-1:0] i_corner_a = '0, i_corner_b = '0, i_corner_c = '0;
    logic [FIELD_W-1:0] i_plane_normal = '0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               o_valid, o_hit;
    logic signed [20:0] o_point_x, o_point_y, o_point_z;

    segment_triangle_interior_hit_core #(.COORD_WIDTH(CW)) dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the config registers, as the predictor sees them.
    logic [EPS_W-1:0]    eps_shadow    = EPS_RESET;
    logic [MARGIN_W-1:0] margin_shadow = MARGIN_RESET;

    seg_tri_t  pending_cmds[$];
    crossing_t expected_crossings[$];
    seg_tri_t  cur_cmd;
    int        mismatches = 0;
    int        idle_cycles = 0;

    // Append one command to the tail of the pending queue.
    function automatic void queue_cmd(seg_tri_t it);
        pending_cmds.insert(pending_cmds.size(), it);
    endfunction

    // ------------------------------------------------------------------
    // Crossing predictor
    // ------------------------------------------------------------------
    function automatic longint coord_of(logic [FIELD_W-1:0] w, int k);
        logic signed [CW-1:0] f;
        f = w[k*CW +: CW];
        return longint'(f);
    endfunction

    function automatic wide_t wmul(longint x, longint y);
        wide_t wx, wy;
        wx = x;
        wy = y;
        return wx * wy;
    endfunction

    function automatic longint dot(longint p[3], longint q[3]);
        return p[0]*q[0] + p[1]*q[1] + p[2]*q[2];
    endfunction

    function automatic crossing_t predict_crossing(seg_tri_t it, logic [EPS_W-1:0] eps,
                                                   logic [MARGIN_W-1:0] margin);
        longint s[3], e[3], a[3], b[3], c[3], n[3], ds[3], de[3], p[3];
        longint v0[3], v1[3], v2[3];
        longint d0, d1, eps_q, num, den, d, r, m, one;
        longint d00, d01, d11, d20, d21;
        longint unsigned tq, mag;
        wide_t quot, denom, rhs, lv, lw, lu;
        crossing_t res;
        res = '{1'b0, '0, '0, '0};
        for (int k = 0; k < 3; k++) begin
            s[k] = coord_of(it.s, k); e[k] = coord_of(it.e, k);
            a[k] = coord_of(it.a, k); b[k] = coord_of(it.b, k);
            c[k] = coord_of(it.c, k); n[k] = coord_of(it.n, k);
            ds[k] = s[k] - a[k]; de[k] = e[k] - a[k];
        end
        d0 = dot(ds, n);
        d1 = dot(de, n);
        eps_q = longint'(eps) << EPS_SHIFT;
        // same side of the plane, beyond tolerance
        if ((d0 > eps_q && d1 > eps_q) || (d0 < -eps_q && d1 < -eps_q)) return res;
        num = d0;
        den = d0 - d1;
        if (den > -PAR_LIMIT && den < PAR_LIMIT) return res;  // near parallel
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num < 0 || num > den) return res;  // crossing off the segment
        if (num == den) begin
            tq = 64'd1 << Q_BITS;
        end else begin
            quot = num;
            quot = (quot <<< Q_BITS) / den;
            tq = quot[63:0];
        end
        for (int k = 0; k < 3; k++) begin
            d = e[k] - s[k];
            mag = longint'(d < 0 ? -d : d) * tq;
            r = longint'((mag + (64'd1 << (Q_BITS - 1))) >> Q_BITS);
            p[k] = d < 0 ? s[k] - r : s[k] + r;
            v0[k] = b[k] - a[k]; v1[k] = c[k] - a[k]; v2[k] = p[k] - a[k];
        end
        d00 = dot(v0, v0); d01 = dot(v0, v1); d11 = dot(v1, v1);
        d20 = dot(v2, v0); d21 = dot(v2, v1);
        denom = wmul(d00, d11) - wmul(d01, d01);
        if (denom <= 0) return res;  // degenerate triangle
        m = longint'(margin);
        one = longint'(1) << ONE_SHIFT;
        rhs = wmul(m * d00, d11) - wmul(m * d01, d01);
        lv = wmul(d11 * one, d20) - wmul(d01 * one, d21);
        lw = wmul(d00 * one, d21) - wmul(d01 * one, d20);
        lu = wmul(d00 * one, d11) - wmul(d01 * one, d01) - (lv + lw);
        if (lu > rhs && lv > rhs && lw > rhs) begin
            res.hit = 1'b1;
            res.x = p[0][20:0];
            res.y = p[1][20:0];
            res.z = p[2][20:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [FIELD_W-1:0] pack3(longint x, longint y, longint z);
        longint lim;
        lim = (longint'(1) << (CW - 1)) - 1;
        if (x > lim) x = lim; if (x < -lim) x = -lim;
        if (y > lim) y = lim; if (y < -lim) y = -lim;
        if (z > lim) z = lim; if (z < -lim) z = -lim;
        return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
    endfunction

    function automatic longint rnd_signed(int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic real frac();
        return $urandom_range(0, 10000) / 10000.0;
    endfunction

    // Well-formed command: a real triangle, its normal, and a segment through a
    // chosen point. Mode picks a clean crossing, an edge point, same side,
    // a segment lying in the plane or a collapsed triangle.
    function automatic seg_tri_t make_crossing(int mode);
        seg_tri_t it;
        int span;
        longint a[3], b[3], c[3], n[3];
        real cr[3], len, w1, w2, h, f0, f1, pt[3], tang[3];
        span = ($urandom_range(0, 3) == 0) ? 200000 : $urandom_range(8, 4000);
        for (int k = 0; k < 3; k++) begin
            a[k] = rnd_signed(span);
            b[k] = a[k] + rnd_signed(span);
            c[k] = a[k] + rnd_signed(span);
        end
        if (mode == 4) begin
            // collinear corners
            for (int k = 0; k < 3; k++) c[k] = a[k] + 2 * (b[k] - a[k]);
        end
        cr[0] = real'((b[1]-a[1])*(c[2]-a[2]) - (b[2]-a[2])*(c[1]-a[1]));
        cr[1] = real'((b[2]-a[2])*(c[0]-a[0]) - (b[0]-a[0])*(c[2]-a[2]));
        cr[2] = real'((b[0]-a[0])*(c[1]-a[1]) - (b[1]-a[1])*(c[0]-a[0]));
        len = $sqrt(cr[0]*cr[0] + cr[1]*cr[1] + cr[2]*cr[2]);
        if (len == 0.0) begin
            cr[0] = 0.0; cr[1] = 0.0; cr[2] = 1.0; len = 1.0;
        end
        for (int k = 0; k < 3; k++) n[k] = $rtoi(cr[k] / len * NORM_ONE);
        w1 = frac(); w2 = frac();
        if (w1 + w2 > 1.0) begin
            w1 = 1.0 - w1; w2 = 1.0 - w2;
        end
        if (mode == 1) w2 = 0.0;  // on an edge
        h = 1.0 + frac() * span;
        f0 = frac();
        f1 = (mode == 2) ? -frac() * 0.9 : frac();
        if (mode == 3) begin
            f0 = 0.0; f1 = 0.0;
        end
        for (int k = 0; k < 3; k++) begin
            pt[k] = a[k] + w1 * (b[k] - a[k]) + w2 * (c[k] - a[k]);
            tang[k] = (frac() - 0.5) * h * 0.2;
        end
        it.a = pack3(a[0], a[1], a[2]);
        it.b = pack3(b[0], b[1], b[2]);
        it.c = pack3(c[0], c[1], c[2]);
        it.n = pack3(n[0], n[1], n[2]);
        it.s = pack3($rtoi(pt[0] + cr[0]/len*h*f0 + tang[0]),
                     $rtoi(pt[1] + cr[1]/len*h*f0 + tang[1]),
                     $rtoi(pt[2] + cr[2]/len*h*f0 + tang[2]));
        it.e = pack3($rtoi(pt[0] - cr[0]/len*h*f1 - tang[0]),
                     $rtoi(pt[1] - cr[1]/len*h*f1 - tang[1]),
                     $rtoi(pt[2] - cr[2]/len*h*f1 - tang[2]));
        return it;
    endfunction

    function automatic logic [FIELD_W-1:0] rnd_word();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[FIELD_W-1:0];
    endfunction

    function automatic seg_tri_t make_noise();
        seg_tri_t it;
        it.s = rnd_word(); it.e = rnd_word(); it.a = rnd_word();
        it.b = rnd_word(); it.c = rnd_word(); it.n = rnd_word();
        return it;
    endfunction

    // Triangle in the z = 0 plane with its normal along the z axis, signed by nz.
    function automatic seg_tri_t flat_tri(longint sx, longint sy, longint sz,
                                          longint ex, longint ey, longint ez, longint nz);
        seg_tri_t it;
        it.a = pack3(0, 0, 0);
        it.b = pack3(1600, 0, 0);
        it.c = pack3(0, 1600, 0);
        it.n = pack3(0, 0, nz);
        it.s = pack3(sx, sy, sz);
        it.e = pack3(ex, ey, ez);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of random length with random gaps.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                expected_crossings.insert(expected_crossings.size(),
                    predict_crossing(cur_cmd, eps_shadow, margin_shadow));
            end
            if (!(i_start && o_busy)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_start <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    i_seg_start    <= cur_cmd.s;
                    i_seg_end      <= cur_cmd.e;
                    i_corner_a     <= cur_cmd.a;
                    i_corner_b     <= cur_cmd.b;
                    i_corner_c     <= cur_cmd.c;
                    i_plane_normal <= cur_cmd.n;
                    i_start <= 1'b1;
                    if (burst_left <= 1) begin
                        // long bursts now and then, so back-to-back stretches occur
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest expectation.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        crossing_t want;
        if (i_rst_n && o_valid) begin
            if (expected_crossings.size() == 0) begin
                report_mismatch("unexpected result beat, hit", o_hit, 0);
            end else begin
                want = expected_crossings.pop_front();
                if (o_hit !== want.hit) report_mismatch("hit", o_hit, want.hit);
                if (o_point_x !== want.x) report_mismatch("point_x", o_point_x, want.x);
                if (o_point_y !== want.y) report_mismatch("point_y", o_point_y, want.y);
                if (o_point_z !== want.z) report_mismatch("point_z", o_point_z, want.z);
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    task automatic drain();
        while (pending_cmds.size() > 0 || i_start || expected_crossings.size() > 0)
            @(posedge i_clk);
        // let the pipeline empty of beats that carry no result yet
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == REG_WORLD_EPS) eps_shadow = data[EPS_W-1:0];
        else margin_shadow = data[MARGIN_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_random(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      queue_cmd(make_crossing(0));
            else if (pick < 65) queue_cmd(make_crossing(1));
            else if (pick < 75) queue_cmd(make_crossing(2));
            else if (pick < 80) queue_cmd(make_crossing(3));
            else if (pick < 85) queue_cmd(make_crossing(4));
            else                queue_cmd(make_noise());
        end
    endtask

    initial begin
        seg_tri_t it;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset register values.
        it.s = '0; it.e = '0; it.a = '0; it.b = '0; it.c = '0; it.n = '0;
        queue_cmd(it);                                    // all zero
        it.s = '1; it.e = '1; it.a = '1; it.b = '1; it.c = '1; it.n = '1;
        queue_cmd(it);                                    // all ones
        queue_cmd(flat_tri(300, 300, 1048575, 300, 300, -1048575, NORM_ONE));
        queue_cmd(flat_tri(-1048575, -1048575, 1048575,
                           1048575, 1048575, -1048575, NORM_ONE));
        queue_cmd(flat_tri(300, 300, 100, 300, 300, 0, NORM_ONE)); // end on plane
        queue_cmd(flat_tri(300, 300, 0, 300, 300, -50, NORM_ONE)); // start on plane
        queue_cmd(flat_tri(300, 300, 100, 300, 300, 40, NORM_ONE)); // same side
        queue_cmd(flat_tri(300, 300, -100, 300, 300, -4, NORM_ONE));
        queue_cmd(flat_tri(100, 100, 0, 900, 200, 0, NORM_ONE)); // in plane
        queue_cmd(flat_tri(300, 300, 3, 300, 300, 1, 1));    // near parallel
        queue_cmd(flat_tri(300, 300, 3, 300, 300, 1, 100));  // off the segment
        queue_cmd(flat_tri(300, 300, -3, 300, 300, -1, -100));
        queue_cmd(flat_tri(800, 0, 50, 800, 0, -50, NORM_ONE)); // on an edge
        queue_cmd(flat_tri(2, 2, 50, 2, 2, -50, NORM_ONE));    // at the margin
        queue_cmd(flat_tri(3000, 3000, 50, 3000, 3000, -50, NORM_ONE)); // outside
        queue_cmd(flat_tri(300, 500, 70, 500, 300, -30, -NORM_ONE));
        it = flat_tri(300, 300, 50, 300, 300, -50, NORM_ONE);
        it.c = pack3(3200, 0, 0);                         // collinear corners
        queue_cmd(it);
        it = flat_tri(300, 300, 50, 300, 300, -50, NORM_ONE);
        it.b = it.a; it.c = it.a;                         // point triangle
        queue_cmd(it);
        queue_cmd(make_crossing(0));
        queue_cmd(make_crossing(1));
        queue_random(100);
        drain();

        // Extremes of both registers, then random settings.
        write_reg(REG_WORLD_EPS, '0);
        write_reg(REG_BARY_MARGIN, '0);
        queue_random(130);
        drain();
        write_reg(REG_WORLD_EPS, 20'hFFFFF);
        write_reg(REG_BARY_MARGIN, 20'h0FFFF);
        queue_random(100);
        drain();
        write_reg(REG_WORLD_EPS, 20'($urandom_range(0, 1048575)));
        write_reg(REG_BARY_MARGIN, 20'($urandom_range(0, 65535)));
        queue_random(100);
        drain();
        write_reg(REG_WORLD_EPS, 20'($urandom_range(0, 64)));
        write_reg(REG_BARY_MARGIN, 20'($urandom_range(0, 4000)));
        queue_random(200);
        drain();

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
